// ===== src/rsmp_pkg.sv =====
package rsmp_pkg;

  // Fixed field widths.
  localparam int FRAC_W = 16;
  localparam int LEN_W  = 24;
  localparam int STEP_W = 16;
  localparam int POS_W  = 24;
  localparam int DIST_W = 26;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 1;

  // Largest supported per-segment cap and the count width that covers it.
  localparam int MAX_PER_SEGMENT_LIMIT = 64;
  localparam int CNT_W = $clog2(MAX_PER_SEGMENT_LIMIT + 1);

  // Parameter defaults.
  localparam int MAX_PER_SEGMENT_DEF = 64;
  localparam int OFFSET_WIDTH_DEF    = 16;

  // Register reset values.
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(256);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1024);

  // Saturation limit of the leftover distance.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_STEP = 1'b1;

  // One segment request handed from the front to the back.
  typedef struct packed {
    logic [POS_W-1:0]  c0;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  delta;
    logic [CNT_W-1:0]  cnt;
    logic              clip;
  } seg_ctl_t;

endpackage

// ===== src/polyline_fixed_step_resampler.sv =====
// A point that emits nothing passes through the capture, position and classify states.
// A point that opens a segment also runs the 24-bit serial sample count and the push into
// the back queue, which waits while the queue is full. Each sample takes a multiply, the serial
// divider of the interpolation and the output register; the front takes no new point until idle.
// Reset (synchronous, active high) empties the queue, clears the stroke state and
// restores stroke length 256 (1.0) and step 1024 (4.0).
module polyline_fixed_step_resampler #(
  parameter int MAX_PER_SEGMENT = rsmp_pkg::MAX_PER_SEGMENT_DEF,
  parameter int OFFSET_WIDTH    = rsmp_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rsmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsmp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           first_point,
  input  logic [rsmp_pkg::FRAC_W-1:0]    position_fraction,
  input  logic signed [OFFSET_WIDTH-1:0] offset_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OFFSET_WIDTH-1:0] resampled_offset,
  output logic                           run_last,
  output logic                           clipped
);

  import rsmp_pkg::*;

  localparam int Q_W = $bits(seg_ctl_t) + 2 * OFFSET_WIDTH;

  logic                           push;
  logic                           pop;
  logic                           q_full;
  logic                           q_empty;
  seg_ctl_t                       push_ctl;
  seg_ctl_t                       pop_ctl;
  logic signed [OFFSET_WIDTH-1:0] push_o1;
  logic signed [OFFSET_WIDTH-1:0] push_o2;
  logic signed [OFFSET_WIDTH-1:0] pop_o1;
  logic signed [OFFSET_WIDTH-1:0] pop_o2;
  logic [Q_W-1:0]                 q_rdata;

  // Front: takes points, keeps stroke state, counts samples per segment.
  rsmp_front #(
    .MAX_PER_SEGMENT (MAX_PER_SEGMENT),
    .OFFSET_WIDTH    (OFFSET_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .first_point       (first_point),
    .position_fraction (position_fraction),
    .offset_value      (offset_value),
    .q_full            (q_full),
    .push              (push),
    .push_ctl          (push_ctl),
    .push_o1           (push_o1),
    .push_o2           (push_o2)
  );

  // Segment request queue.
  rsmp_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_ctl, push_o1, push_o2}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {pop_ctl, pop_o1, pop_o2} = q_rdata;

  // Back: interpolates each sample of a segment.
  rsmp_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .pop              (pop),
    .pop_ctl          (pop_ctl),
    .pop_o1           (pop_o1),
    .pop_o2           (pop_o2),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .resampled_offset (resampled_offset),
    .run_last         (run_last),
    .clipped          (clipped)
  );

`ifndef NO_ASSERTIONS
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("segment queue overflow");
  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("segment queue underflow");
  // An accepted point keeps the front busy on the next cycle.
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front accepted a point while busy");
  // Every pushed segment carries at least one sample.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_ctl.cnt != '0))
    else $error("empty segment request");
`endif

endmodule

// ===== src/rsmp_div.sv =====
module rsmp_div #(
  parameter int DEND_W = 24,
  parameter int DSOR_W = 16,
  parameter int QUOT_W = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSOR_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient,
  output logic [DSOR_W-1:0] remainder
);

  localparam int SH_W  = DSOR_W + QUOT_W - 1;
  localparam int CMP_W = (DEND_W > SH_W) ? DEND_W : SH_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DEND_W-1:0] rem;
  logic [SH_W-1:0]   ds;
  logic [QUOT_W-1:0] quot;
  logic [CMP_W-1:0]  rem_x;
  logic [CMP_W-1:0]  ds_x;
  logic              ge;

  // One quotient bit per cycle, most significant first; the dividend must be
  // below the divisor shifted up by the quotient width.
  assign rem_x = CMP_W'(rem);
  assign ds_x  = CMP_W'(ds);
  assign ge    = rem_x >= ds_x;

  assign quotient  = quot;
  assign remainder = DSOR_W'(rem);

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      ds   <= SH_W'(divisor) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= DEND_W'(rem_x - ds_x);
      end
      quot <= {quot[QUOT_W-2:0], ge};
      ds   <= ds >> 1;
    end
  end

endmodule

// ===== src/rsmp_queue.sv =====
module rsmp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rp];

  // Two-entry request queue between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ===== src/rsmp_front.sv =====
module rsmp_front #(
  parameter int MAX_PER_SEGMENT = rsmp_pkg::MAX_PER_SEGMENT_DEF,
  parameter int OFFSET_WIDTH    = rsmp_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rsmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rsmp_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 first_point,
  input  logic [rsmp_pkg::FRAC_W-1:0]          position_fraction,
  input  logic signed [OFFSET_WIDTH-1:0]       offset_value,
  input  logic                                 q_full,
  output logic                                 push,
  output rsmp_pkg::seg_ctl_t                   push_ctl,
  output logic signed [OFFSET_WIDTH-1:0]       push_o1,
  output logic signed [OFFSET_WIDTH-1:0]       push_o2
);

  import rsmp_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_POS, F_CLASS, F_DIV, F_PUSH} fstate_t;

  fstate_t                  state;
  logic [LEN_W-1:0]         len;
  logic [STEP_W-1:0]        step;
  logic                     fp_r;
  logic [FRAC_W-1:0]        frac_r;
  logic signed [OFFSET_WIDTH-1:0] off_r;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         prev_position;
  logic signed [OFFSET_WIDTH-1:0] prev_offset;
  logic [DIST_W-1:0]        distance_to_next;
  logic                     have_point;
  logic [POS_W-1:0]         delta_r;
  logic [POS_W-1:0]         c0_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     clip_r;

  logic [STEP_W-1:0]        step_eff;
  logic [POS_W-1:0]         delta;
  logic [POS_W-1:0]         back;
  logic [DIST_W:0]          back_sum;
  logic                     emit;
  logic                     div_start;
  logic                     div_done;
  logic [POS_W-1:0]         div_q;
  logic [STEP_W-1:0]        div_r;
  logic                     clip_next;
  logic [CNT_W-1:0]         cnt_next;

  // Segment geometry for the point in hand.
  assign step_eff = (step == '0) ? STEP_W'(1) : step;
  assign delta    = pos - prev_position;
  assign back     = prev_position - pos;
  assign back_sum = (DIST_W + 1)'(distance_to_next) + (DIST_W + 1)'(back);
  assign emit     = !(fp_r || !have_point) && (pos > prev_position)
                    && (distance_to_next <= DIST_W'(delta));
  assign div_start = (state == F_CLASS) && emit;

  // Sample count of the segment: floor((delta - d) / step) + 1, capped.
  rsmp_div #(
    .DEND_W (POS_W),
    .DSOR_W (STEP_W),
    .QUOT_W (POS_W)
  ) u_cnt_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (delta - POS_W'(distance_to_next)),
    .divisor   (step_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign clip_next = div_q >= POS_W'(MAX_PER_SEGMENT);
  assign cnt_next  = clip_next ? CNT_W'(MAX_PER_SEGMENT) : CNT_W'(div_q + POS_W'(1));

  assign in_ready = state == F_IDLE;
  assign push     = (state == F_PUSH) && !q_full;
  assign push_o1  = prev_offset;
  assign push_o2  = off_r;

  always_comb begin
    push_ctl.c0    = c0_r;
    push_ctl.step  = step_eff;
    push_ctl.delta = delta_r;
    push_ctl.cnt   = cnt_r;
    push_ctl.clip  = clip_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= LEN_RESET;
      step <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STROKE_LENGTH: len  <= LEN_W'(cfg_wdata);
        CFG_RESAMPLE_STEP: step <= STEP_W'(cfg_wdata);
        default:           len  <= len;
      endcase
    end
  end

  // Point sequencer and stroke state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= F_IDLE;
      prev_position    <= '0;
      prev_offset      <= '0;
      distance_to_next <= '0;
      have_point       <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_POS;
          end
        end
        F_POS: begin
          state <= F_CLASS;
        end
        F_CLASS: begin
          if (fp_r || !have_point) begin
            prev_position    <= pos;
            prev_offset      <= off_r;
            distance_to_next <= '0;
            have_point       <= 1'b1;
            state            <= F_IDLE;
          end else if (emit) begin
            state <= F_DIV;
          end else begin
            if (pos > prev_position) begin
              distance_to_next <= distance_to_next - DIST_W'(delta);
            end else begin
              distance_to_next <= (back_sum > (DIST_W + 1)'(DIST_MAX)) ? DIST_MAX
                                  : DIST_W'(back_sum);
            end
            prev_position <= pos;
            prev_offset   <= off_r;
            state         <= F_IDLE;
          end
        end
        F_DIV: begin
          if (div_done) begin
            distance_to_next <= DIST_W'(step_eff - div_r);
            state            <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            prev_position <= pos;
            prev_offset   <= off_r;
            state         <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      fp_r   <= first_point;
      frac_r <= position_fraction;
      off_r  <= offset_value;
    end
    if (state == F_POS) begin
      pos <= POS_W'((FRAC_W + LEN_W)'(frac_r) * (FRAC_W + LEN_W)'(len) >> FRAC_W);
    end
    if (div_start) begin
      delta_r <= delta;
      c0_r    <= POS_W'(distance_to_next);
    end
    if (state == F_DIV && div_done) begin
      cnt_r  <= cnt_next;
      clip_r <= clip_next;
    end
  end

endmodule

// ===== src/rsmp_back.sv =====
module rsmp_back #(
  parameter int OFFSET_WIDTH = rsmp_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           pop,
  input  rsmp_pkg::seg_ctl_t             pop_ctl,
  input  logic signed [OFFSET_WIDTH-1:0] pop_o1,
  input  logic signed [OFFSET_WIDTH-1:0] pop_o2,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OFFSET_WIDTH-1:0] resampled_offset,
  output logic                           run_last,
  output logic                           clipped
);

  import rsmp_pkg::*;

  localparam int MAG_W  = OFFSET_WIDTH + POS_W;
  localparam int DEND_W = OFFSET_WIDTH + POS_W + 2;
  localparam int DSOR_W = POS_W + 1;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_START, B_WAIT, B_OUT} bstate_t;

  bstate_t                        state;
  logic signed [OFFSET_WIDTH-1:0] o1;
  logic                           neg;
  logic [OFFSET_WIDTH-1:0]        absd;
  logic [POS_W-1:0]               c;
  logic [STEP_W-1:0]              step;
  logic [POS_W-1:0]               delta;
  logic [CNT_W-1:0]               cnt;
  logic                           clip;
  logic [CNT_W-1:0]               idx;
  logic [MAG_W-1:0]               mag;

  logic signed [OFFSET_WIDTH:0]   diff;
  logic                           div_done;
  logic [OFFSET_WIDTH-1:0]        div_q;
  logic [DSOR_W-1:0]              div_r;
  logic                           load;
  logic                           last;
  logic [OFFSET_WIDTH:0]          value;

  assign diff = (OFFSET_WIDTH + 1)'(pop_o2) - (OFFSET_WIDTH + 1)'(pop_o1);
  assign pop  = (state == B_IDLE) && !q_empty;
  assign load = (state == B_OUT) && (!out_valid || out_ready);
  assign last = (idx + CNT_W'(1)) == cnt;

  // Rounded quotient: (2 * |o2 - o1| * c + delta) / (2 * delta).
  rsmp_div #(
    .DEND_W (DEND_W),
    .DSOR_W (DSOR_W),
    .QUOT_W (OFFSET_WIDTH)
  ) u_interp_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == B_START),
    .dividend  ((DEND_W'(mag) << 1) + DEND_W'(delta)),
    .divisor   (DSOR_W'(delta) << 1),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign value = neg ? ((OFFSET_WIDTH + 1)'(o1) - (OFFSET_WIDTH + 1)'(div_q))
                     : ((OFFSET_WIDTH + 1)'(o1) + (OFFSET_WIDTH + 1)'(div_q));

  // Sample sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_MUL;
          end
        end
        B_MUL:   state <= B_START;
        B_START: state <= B_WAIT;
        B_WAIT: begin
          if (div_done) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (load) begin
            out_valid <= 1'b1;
            state     <= last ? B_IDLE : B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Segment and sample datapath.
  always_ff @(posedge clk) begin
    if (pop) begin
      o1    <= pop_o1;
      neg   <= diff[OFFSET_WIDTH];
      absd  <= OFFSET_WIDTH'(diff[OFFSET_WIDTH] ? -diff : diff);
      c     <= pop_ctl.c0;
      step  <= pop_ctl.step;
      delta <= pop_ctl.delta;
      cnt   <= pop_ctl.cnt;
      clip  <= pop_ctl.clip;
      idx   <= '0;
    end
    if (state == B_MUL) begin
      mag <= MAG_W'(absd) * MAG_W'(c);
    end
    if (load) begin
      resampled_offset <= OFFSET_WIDTH'(value);
      run_last         <= last;
      clipped          <= clip;
      c                <= c + POS_W'(step);
      idx              <= idx + CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  // The rounded quotient never leaves a remainder as large as the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT) |-> (div_r < (DSOR_W'(delta) << 1)))
    else $error("interpolation remainder out of range");
  // Samples of one segment never run past its count.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT) |-> (idx < cnt))
    else $error("sample index past segment count");
  // A segment is only taken once the previous one has finished.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_MUL))
    else $error("segment pop out of sequence");
`endif

endmodule

// ===== tb/polyline_fixed_step_resampler_tb.sv =====
`timescale 1ns / 1ps

module polyline_fixed_step_resampler_tb;
  import rsmp_pkg::*;

  localparam int MAX_SEG    = 64;
  localparam int OFF_W      = 16;
  localparam int DRAIN_WAIT = 80;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [OFF_W-1:0] offs;
    logic                    last;
    logic                    clip;
  } sample_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic                    first_point;
  logic [FRAC_W-1:0]       position_fraction;
  logic signed [OFF_W-1:0] offset_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OFF_W-1:0] resampled_offset;
  logic                    run_last;
  logic                    clipped;

  // Expected samples, oldest first.
  sample_t pending_samples[$];

  // Shadow of the stroke state and the registers.
  longint stroke_len;
  longint step_len;
  longint last_pos;
  longint last_off;
  longint gap_left;
  bit     stroke_open;

  int     send_idle_pct;
  int     recv_idle_pct;
  int     mismatches;
  int     points_sent;
  int     samples_seen;
  int     clipped_seen;
  longint cycles;

  polyline_fixed_step_resampler dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_point(first_point), .position_fraction(position_fraction),
    .offset_value(offset_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .resampled_offset(resampled_offset), .run_last(run_last), .clipped(clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded interpolation between two offsets, ties away from zero.
  function automatic longint lerp_offset(longint o1, longint o2, longint c, longint d);
    longint dl;
    longint mag;
    longint q;
    dl = o2 - o1;
    mag = (dl < 0 ? -dl : dl) * c;
    q = (2 * mag + d) / (2 * d);
    return dl < 0 ? o1 - q : o1 + q;
  endfunction

  // Works out the samples that one accepted point causes.
  task automatic predict_point(bit fp, longint frac, longint off);
    longint pos;
    longint step;
    longint delta;
    longint total;
    longint cnt;
    bit     clip;
    sample_t s;
    pos = (frac * stroke_len) >> 16;
    step = (step_len == 0) ? 1 : step_len;
    if (fp || !stroke_open) begin
      gap_left = 0;
      stroke_open = 1'b1;
    end else if (pos > last_pos) begin
      delta = pos - last_pos;
      if (gap_left <= delta) begin
        total = (delta - gap_left) / step + 1;
        clip = total > MAX_SEG;
        cnt = clip ? MAX_SEG : total;
        for (longint i = 0; i < cnt; i++) begin
          s.offs = OFF_W'(lerp_offset(last_off, off, gap_left + i * step, delta));
          s.last = (i + 1 == cnt);
          s.clip = clip;
          pending_samples = {pending_samples, s};
        end
        gap_left = gap_left + total * step - delta;
      end else begin
        gap_left = gap_left - delta;
      end
    end else begin
      gap_left = gap_left + (last_pos - pos);
      if (gap_left > longint'(DIST_MAX)) gap_left = longint'(DIST_MAX);
    end
    last_pos = pos;
    last_off = off;
  endtask

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Sends one point and records what it should cause.
  task automatic send_point(bit fp, logic [FRAC_W-1:0] frac, logic signed [OFF_W-1:0] off);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    first_point = fp;
    position_fraction = frac;
    offset_value = off;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_point(fp, frac, off);
    points_sent++;
  endtask

  // Holds the sender back until the block has nothing left to deliver.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_STROKE_LENGTH) stroke_len = val;
    else step_len = val[STEP_W-1:0];
  endtask

  // Reset values: a stroke that opens without a start flag, then short moves.
  task automatic test_reset_defaults();
    send_point(1'b0, 16'h0000, 16'sh8000);
    send_point(1'b0, 16'hFFFF, 16'sh7FFF);
    send_point(1'b0, 16'hFFFF, 16'sh0100);
    send_point(1'b0, 16'h1000, -16'sh0100);
    send_point(1'b1, 16'h8000, 16'sh0000);
  endtask

  // Field extremes, the sample cap, a zero step and backward moves.
  task automatic test_extremes();
    write_reg(CFG_STROKE_LENGTH, 24'hFFFFFF);
    write_reg(CFG_RESAMPLE_STEP, 24'h000001);
    send_point(1'b1, 16'h0000, 16'sh8000);
    send_point(1'b0, 16'hFFFF, 16'sh7FFF);
    send_point(1'b0, 16'h0000, 16'sh7FFF);
    send_point(1'b0, 16'h0000, -16'sh0001);
    send_point(1'b0, 16'h0001, 16'sh8000);
    write_reg(CFG_RESAMPLE_STEP, 24'h00FFFF);
    send_point(1'b1, 16'h0000, 16'sh7FFF);
    send_point(1'b0, 16'hFFFF, 16'sh8000);
    send_point(1'b0, 16'h7FFF, 16'sh1234);
    send_point(1'b0, 16'hFFFF, -16'sh1234);
    write_reg(CFG_RESAMPLE_STEP, 24'h000000);
    write_reg(CFG_STROKE_LENGTH, 24'h000001);
    send_point(1'b1, 16'h0000, 16'sh0000);
    send_point(1'b0, 16'hFFFF, 16'sh0055);
    write_reg(CFG_STROKE_LENGTH, 24'h001000);
    send_point(1'b1, 16'h0000, 16'sh0003);
    send_point(1'b0, 16'h0200, -16'sh0003);
    send_point(1'b0, 16'h0300, 16'sh0001);
  endtask

  // Random strokes: mostly forward moves of a few samples, some noise points.
  task automatic test_random(int n_items);
    longint len;
    longint stp;
    longint span;
    longint frac;
    int     left;
    len = (($urandom_range(0, 1) == 0) ? 65536 : $urandom_range(1, 24'hFFFFFF));
    stp = $urandom_range(1, 16'hFFFF);
    write_reg(CFG_STROKE_LENGTH, CFG_W'(len));
    write_reg(CFG_RESAMPLE_STEP, CFG_W'(stp));
    span = (stp * 4 * 65536) / len;
    if (span < 1) span = 1;
    if (span > 65535) span = 65535;
    frac = 0;
    left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (left == 0) begin
        left = $urandom_range(4, 20);
        frac = $urandom_range(0, 16'hFFFF);
        send_point($urandom_range(0, 9) != 0, FRAC_W'(frac), OFF_W'($urandom));
      end else if ($urandom_range(0, 99) < 15) begin
        frac = $urandom_range(0, 16'hFFFF);
        send_point(1'b0, FRAC_W'(frac), OFF_W'($urandom));
      end else begin
        frac = frac + $urandom_range(0, span);
        if (frac > 65535) frac = $urandom_range(0, 255);
        send_point(1'b0, FRAC_W'(frac), OFF_W'($urandom));
      end
      left--;
    end
  endtask

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Each delivered sample against the oldest expectation.
  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report("unexpected sample", resampled_offset, 0);
      end else begin
        want = pending_samples.pop_front();
        samples_seen++;
        if (clipped) clipped_seen++;
        if (resampled_offset !== want.offs) report("resampled_offset", resampled_offset, want.offs);
        if (run_last !== want.last) report("run_last", run_last, want.last);
        if (clipped !== want.clip) report("clipped", clipped, want.clip);
      end
    end
  end

  // Overall cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    first_point = 1'b0;
    position_fraction = '0;
    offset_value = '0;
    stroke_len = LEN_RESET;
    step_len = STEP_RESET;
    last_pos = 0;
    last_off = 0;
    gap_left = 0;
    stroke_open = 1'b0;
    mismatches = 0;
    points_sent = 0;
    samples_seen = 0;
    clipped_seen = 0;
    cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 69;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_extremes();
    test_random(70);
    test_random(70);
    send_idle_pct = 69;
    recv_idle_pct = 7;
    test_random(70);
    test_random(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(65);
    test_random(65);
    wait_idle();

    $display("Covered %0d points and %0d samples, %0d of them clipped,",
             points_sent, samples_seen, clipped_seen);
    $display("over reset, extreme and random register settings and three stall patterns.");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
